/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, sampled on the rising clock edge and
// held off while the synchronous active-low reset is asserted
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* design/rtml_pkg.sv */
// ----------------------------------------------------------------------------
// rtml_pkg
// types and codes shared by the route table lookup unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rtml_pkg;

    localparam int unsigned ADDR_W   = 32;
    localparam int unsigned PORT_W   = 4;
    localparam int unsigned METRIC_W = 32;
    localparam int unsigned S_DATA_W = 168;
    localparam int unsigned M_DATA_W = 104;

    typedef enum logic [1:0] {
        MODE_ADD    = 2'd0,
        MODE_DEL    = 2'd1,
        MODE_LOOKUP = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_NONE = 2'd2
    } t_status;

    typedef struct packed {
        logic [METRIC_W-1:0] metric;
        logic [PORT_W-1:0]   port;
        logic [ADDR_W-1:0]   source;
        logic [ADDR_W-1:0]   gateway;
        logic [ADDR_W-1:0]   mask;
        logic [ADDR_W-1:0]   dest;
    } t_entry;

    typedef struct packed {
        logic match;
        logic exact;
        logic better;
    } t_cmp;

endpackage

/* design/route_table_metric_lookup_unit.sv */
// ----------------------------------------------------------------------------
// route_table_metric_lookup_unit
// bounded route table with add, delete and lowest-metric masked lookup
// ----------------------------------------------------------------------------
// One item is taken at a time. During a lookup the table memory hands one
// entry per cycle to a single compare unit, which keeps the lowest metric
// (oldest wins on a tie), and its result becomes valid in the same cycle in
// which the next item can enter. A delete scans up to the first exact match
// and then moves every later entry down one slot per cycle through the
// table memory's read and write ports. The table needs no clearing pass
// after reset. The next item is accepted while a result still waits in the
// output register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module route_table_metric_lookup_unit #(
    parameter int unsigned TABLE_DEPTH = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // dest_addr, net_mask, gateway_addr, source_addr, port, metric, zero pad
    input  logic [rtml_pkg::S_DATA_W-1:0]   s_axis_tdata,
    // mode
    input  logic [1:0]                      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // hit_gateway, hit_source, hit_port, hit_metric, zero pad
    output logic [rtml_pkg::M_DATA_W-1:0]   m_axis_tdata,
    // status
    output logic [1:0]                      m_axis_tuser
);
    import rtml_pkg::*;

    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_FINISH
    } t_state;

    t_state              r_state;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       r_rd_idx;
    logic                r_pend;
    logic [CW-1:0]       r_pend_pos;
    logic                r_is_lookup;
    logic                r_found;
    logic [ADDR_W-1:0]   r_key_addr;
    logic [ADDR_W-1:0]   r_key_mask;
    t_status             r_res_status;
    logic [ADDR_W-1:0]   r_res_gw;
    logic [ADDR_W-1:0]   r_res_src;
    logic [PORT_W-1:0]   r_res_port;
    logic [METRIC_W-1:0] r_res_metric;
    logic                r_out_valid;
    t_status             r_out_status;
    logic [ADDR_W-1:0]   r_out_gw;
    logic [ADDR_W-1:0]   r_out_src;
    logic [PORT_W-1:0]   r_out_port;
    logic [METRIC_W-1:0] r_out_metric;

    t_entry        in_entry;
    t_entry        rd_data;
    t_entry        wr_data;
    t_cmp          cmp;
    logic          accept;
    logic          not_full;
    logic          add_wr;
    logic          shift_wr;
    logic          issue;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [CW-1:0] pend_prev;

    assign in_entry.dest    = s_axis_tdata[31:0];
    assign in_entry.mask    = s_axis_tdata[63:32];
    assign in_entry.gateway = s_axis_tdata[95:64];
    assign in_entry.source  = s_axis_tdata[127:96];
    assign in_entry.port    = s_axis_tdata[131:128];
    assign in_entry.metric  = s_axis_tdata[163:132];

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign not_full      = (r_count < CW'(TABLE_DEPTH));
    assign add_wr        = accept && (s_axis_tuser == MODE_ADD) && not_full;
    assign shift_wr      = (r_state == S_SHIFT) && r_pend;
    assign issue         = ((r_state == S_SCAN) || (r_state == S_SHIFT)) && (r_rd_idx < r_count);
    assign pend_prev     = r_pend_pos - 1'b1;

    assign wr_en   = add_wr || shift_wr;
    assign wr_addr = add_wr ? r_count[AW-1:0] : pend_prev[AW-1:0];
    assign wr_data = add_wr ? in_entry : rd_data;

    rtml_table #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (issue),
        .i_rd_addr (r_rd_idx[AW-1:0]),
        .o_rd_data (rd_data)
    );

    rtml_cmp u_cmp (
        .i_key_addr    (r_key_addr),
        .i_key_mask    (r_key_mask),
        .i_entry       (rd_data),
        .i_best_metric (r_res_metric),
        .o_res         (cmp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_rd_idx    <= '0;
            r_pend      <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    r_pend <= 1'b0;
                    if (accept) begin
                        r_key_addr   <= in_entry.dest;
                        r_key_mask   <= in_entry.mask;
                        r_res_status <= ST_OK;
                        r_res_gw     <= '0;
                        r_res_src    <= '0;
                        r_res_port   <= '0;
                        r_res_metric <= '0;
                        r_found      <= 1'b0;
                        r_rd_idx     <= '0;
                        unique case (s_axis_tuser)
                            MODE_ADD: begin
                                if (not_full) begin
                                    r_count <= r_count + 1'b1;
                                end else begin
                                    r_res_status <= ST_FULL;
                                end
                                r_state <= S_FINISH;
                            end
                            MODE_DEL: begin
                                r_is_lookup <= 1'b0;
                                r_state     <= S_SCAN;
                            end
                            MODE_LOOKUP: begin
                                r_is_lookup <= 1'b1;
                                r_state     <= S_SCAN;
                            end
                            default: begin
                                r_state <= S_FINISH;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    r_pend     <= issue;
                    r_pend_pos <= r_rd_idx;
                    if (issue) begin
                        r_rd_idx <= r_rd_idx + 1'b1;
                    end
                    if (r_pend && r_is_lookup) begin
                        if (cmp.match && (!r_found || cmp.better)) begin
                            r_found      <= 1'b1;
                            r_res_gw     <= rd_data.gateway;
                            r_res_src    <= rd_data.source;
                            r_res_port   <= rd_data.port;
                            r_res_metric <= rd_data.metric;
                        end
                    end
                    if (r_pend && !r_is_lookup && cmp.exact) begin
                        r_pend   <= 1'b0;
                        r_rd_idx <= r_pend_pos + 1'b1;
                        r_state  <= S_SHIFT;
                    end else if (!issue && !r_pend) begin
                        r_res_status <= (r_is_lookup && r_found) ? ST_OK : ST_NONE;
                        r_state      <= S_FINISH;
                    end
                end
                S_SHIFT: begin
                    r_pend     <= issue;
                    r_pend_pos <= r_rd_idx;
                    if (issue) begin
                        r_rd_idx <= r_rd_idx + 1'b1;
                    end
                    if (!issue && !r_pend) begin
                        r_count      <= r_count - 1'b1;
                        r_res_status <= ST_OK;
                        r_state      <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    r_pend <= 1'b0;
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_res_status;
                        r_out_gw     <= r_res_gw;
                        r_out_src    <= r_res_src;
                        r_out_port   <= r_res_port;
                        r_out_metric <= r_res_metric;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {4'b0, r_out_metric, r_out_port, r_out_src, r_out_gw};

    // table occupancy bound
    `ASSERT_IMP(a_count_max, i_clk, i_rst_n, 1'b1, r_count <= CW'(TABLE_DEPTH))
    // every entry in flight lies inside the table
    `ASSERT_IMP(a_pend_in_range, i_clk, i_rst_n, r_pend, r_pend_pos < r_count)
    // compaction never writes below slot zero
    `ASSERT_IMP(a_shift_pos, i_clk, i_rst_n, shift_wr, r_pend_pos != '0)
    // an add with room grows the table by one
    `ASSERT_NEXT(a_add_grows, i_clk, i_rst_n, add_wr, r_count == CW'($past(r_count) + 1'b1))

endmodule

/* design/rtml_table.sv */
// ----------------------------------------------------------------------------
// rtml_table
// route entry memory, one write port and one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rtml_table #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = 4
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  rtml_pkg::t_entry i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output rtml_pkg::t_entry o_rd_data
);
    import rtml_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* design/rtml_cmp.sv */
// ----------------------------------------------------------------------------
// rtml_cmp
// shared compare unit: masked match, exact match and metric order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rtml_cmp (
    input  logic [rtml_pkg::ADDR_W-1:0]   i_key_addr,
    input  logic [rtml_pkg::ADDR_W-1:0]   i_key_mask,
    input  rtml_pkg::t_entry              i_entry,
    input  logic [rtml_pkg::METRIC_W-1:0] i_best_metric,
    output rtml_pkg::t_cmp                o_res
);
    import rtml_pkg::*;

    always_comb begin
        o_res.match  = ((i_key_addr & i_entry.mask) == i_entry.dest);
        o_res.exact  = (i_key_addr == i_entry.dest) && (i_key_mask == i_entry.mask);
        o_res.better = (i_entry.metric < i_best_metric);
    end

endmodule

/* verif/tb_route_table_metric_lookup_unit.sv */
// ----------------------------------------------------------------------------
// tb_route_table_metric_lookup_unit
// self-checking bench for the route table lookup unit: add, delete, spare
// mode and lowest-metric masked lookup items go in through the input stream,
// a behavioural route table works out each reply, and every reply leaving
// the output stream is checked field by field, with random gaps on both sides
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_route_table_metric_lookup_unit;

    import rtml_pkg::*;

    localparam int unsigned ROUTE_SLOTS = 16;
    localparam int          STALL_LIMIT = 2000;
    localparam int          DRAIN_CYCLES = 40;
    localparam logic [1:0]  MODE_SPARE = 2'd3;

    typedef struct packed {
        logic [1:0] op;
        t_entry     route;
    } t_route_item;

    typedef struct packed {
        t_status             status;
        logic [ADDR_W-1:0]   gateway;
        logic [ADDR_W-1:0]   source;
        logic [PORT_W-1:0]   port;
        logic [METRIC_W-1:0] metric;
    } t_route_reply;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // dest_addr, net_mask, gateway_addr, source_addr, port, metric, zero pad
    logic [S_DATA_W-1:0]   s_axis_tdata;
    // mode
    logic [1:0]            s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // hit_gateway, hit_source, hit_port, hit_metric, zero pad
    logic [M_DATA_W-1:0]   m_axis_tdata;
    // status
    logic [1:0]            m_axis_tuser;

    t_route_item  pending_items[$];
    t_route_reply expected_replies[$];
    logic [63:0]  gen_routes[$];
    t_entry       route_table[ROUTE_SLOTS];
    int           route_count = 0;
    int           mismatch_count = 0;
    int           stall_cycles = 0;

    t_route_item  send_item;
    t_route_reply reply;
    logic         in_fire = 1'b0;
    logic         out_fire = 1'b0;
    logic         send_busy = 1'b0;
    logic         send_calm = 1'b0;
    logic         take_calm = 1'b0;
    int           send_wait = 0;
    int           take_wait = 3;

    route_table_metric_lookup_unit #(
        .TABLE_DEPTH(ROUTE_SLOTS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    always #1 i_clk = ~i_clk;

    function automatic int idle_cycles(input logic calm);
        return calm ? 0 : $urandom_range(0, 18);
    endfunction

    function automatic logic [31:0] rand_mask();
        int len;
        len = $urandom_range(0, 32);
        if ($urandom_range(0, 6) == 0)
            return $urandom();
        return (len == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - len));
    endfunction

    function automatic logic [31:0] rand_metric();
        case ($urandom_range(0, 9))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2, 3, 4, 5: return $urandom_range(0, 3);
            default: return $urandom();
        endcase
    endfunction

    // queues one item and keeps the generator's view of stored dest/mask pairs
    task automatic push_route(input logic [1:0] op, input logic [31:0] dest,
                              input logic [31:0] mask, input logic [31:0] gw,
                              input logic [31:0] src, input logic [3:0] port,
                              input logic [31:0] metric);
        t_route_item it;
        int k;
        it.op = op;
        it.route.dest = dest;
        it.route.mask = mask;
        it.route.gateway = gw;
        it.route.source = src;
        it.route.port = port;
        it.route.metric = metric;
        pending_items.push_back(it);
        if (op == MODE_ADD && gen_routes.size() < ROUTE_SLOTS) begin
            gen_routes.push_back({dest, mask});
        end else if (op == MODE_DEL) begin
            for (k = 0; k < gen_routes.size(); k++) begin
                if (gen_routes[k] == {dest, mask}) begin
                    gen_routes.delete(k);
                    break;
                end
            end
        end
    endtask

    task automatic gen_random_routes(input int count);
        int k, r, phase, pick;
        logic [1:0]  op;
        logic [31:0] dest, mask, gw, src, metric, add_cut, del_cut;
        logic [3:0]  port;
        phase = 2;
        for (k = 0; k < count; k++) begin
            // fill, drain and balanced stretches so the table hits both ends
            if (k % 50 == 0)
                phase = $urandom_range(0, 2);
            case (phase)
                0: begin add_cut = 60; del_cut = 70; end
                1: begin add_cut = 15; del_cut = 55; end
                default: begin add_cut = 30; del_cut = 50; end
            endcase
            r = $urandom_range(0, 99);
            mask = rand_mask();
            dest = $urandom() & mask;
            gw = ($urandom_range(0, 9) == 0) ? 32'h0 : $urandom();
            src = ($urandom_range(0, 9) == 0) ? 32'h0 : $urandom();
            port = $urandom_range(0, 15);
            metric = rand_metric();
            pick = (gen_routes.size() > 0) ? $urandom_range(0, gen_routes.size() - 1) : 0;
            if (r < add_cut) begin
                op = MODE_ADD;
                if (gen_routes.size() > 0 && $urandom_range(0, 9) == 0)
                    {dest, mask} = gen_routes[pick];
                else if ($urandom_range(0, 6) == 0)
                    dest = $urandom();
            end else if (r < del_cut) begin
                op = MODE_DEL;
                if (gen_routes.size() > 0 && $urandom_range(0, 3) != 0) begin
                    {dest, mask} = gen_routes[pick];
                    if ($urandom_range(0, 7) == 0)
                        mask = mask ^ (32'h1 << $urandom_range(0, 31));
                end
            end else if (r < 97) begin
                op = MODE_LOOKUP;
                if (gen_routes.size() > 0 && $urandom_range(0, 4) != 0)
                    dest = gen_routes[pick][63:32] | ($urandom() & ~gen_routes[pick][31:0]);
                else if ($urandom_range(0, 4) == 0)
                    dest = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
                else
                    dest = $urandom();
            end else begin
                op = MODE_SPARE;
                dest = $urandom();
            end
            push_route(op, dest, mask, gw, src, port, metric);
        end
    endtask

    // behavioural route table: insertion order, lowest metric, oldest on a tie
    task automatic apply_route_item(input logic [1:0] op, input t_entry item,
                                    output t_route_reply rep);
        int idx, hit;
        rep = '0;
        rep.status = ST_OK;
        hit = -1;
        case (op)
            MODE_ADD: begin
                if (route_count >= ROUTE_SLOTS) begin
                    rep.status = ST_FULL;
                end else begin
                    route_table[route_count] = item;
                    route_count++;
                end
            end
            MODE_DEL: begin
                for (idx = 0; idx < route_count; idx++)
                    if (hit < 0 && route_table[idx].dest == item.dest &&
                        route_table[idx].mask == item.mask)
                        hit = idx;
                if (hit < 0) begin
                    rep.status = ST_NONE;
                end else begin
                    for (idx = hit; idx + 1 < route_count; idx++)
                        route_table[idx] = route_table[idx + 1];
                    route_count--;
                end
            end
            MODE_LOOKUP: begin
                for (idx = 0; idx < route_count; idx++)
                    if (((item.dest & route_table[idx].mask) == route_table[idx].dest) &&
                        (hit < 0 || route_table[idx].metric < route_table[hit].metric))
                        hit = idx;
                if (hit < 0) begin
                    rep.status = ST_NONE;
                end else begin
                    rep.gateway = route_table[hit].gateway;
                    rep.source = route_table[hit].source;
                    rep.port = route_table[hit].port;
                    rep.metric = route_table[hit].metric;
                end
            end
            default: ;
        endcase
    endtask

    function automatic void check_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $display("%0t %s mismatch: expected %h, got %h", $time, field, want, got);
            mismatch_count++;
        end
    endfunction

    task automatic check_reply();
        t_route_reply want;
        if (expected_replies.size() == 0) begin
            $display("%0t unexpected item: expected none, got status %0d data %h",
                     $time, m_axis_tuser, m_axis_tdata);
            mismatch_count++;
        end else begin
            want = expected_replies.pop_front();
            check_field("status", 32'(want.status), 32'(m_axis_tuser));
            check_field("hit_gateway", want.gateway, m_axis_tdata[31:0]);
            check_field("hit_source", want.source, m_axis_tdata[63:32]);
            check_field("hit_port", 32'(want.port), 32'(m_axis_tdata[67:64]));
            check_field("hit_metric", want.metric, m_axis_tdata[99:68]);
        end
    endtask

    // input side: one item at a time, random gap after each accepted item
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (send_busy && in_fire) begin
                send_busy = 1'b0;
                if ($urandom_range(0, 19) == 0)
                    send_calm = ~send_calm;
                send_wait = idle_cycles(send_calm);
            end
            if (!send_busy) begin
                if (send_wait > 0) begin
                    send_wait--;
                end else if (pending_items.size() > 0) begin
                    send_item = pending_items.pop_front();
                    s_axis_tdata <= {4'b0, send_item.route};
                    s_axis_tuser <= send_item.op;
                    send_busy = 1'b1;
                end
            end
            s_axis_tvalid <= send_busy;
        end
    end

    // output side back-pressure
    always @(negedge i_clk) begin
        if (out_fire) begin
            if ($urandom_range(0, 19) == 0)
                take_calm = ~take_calm;
            take_wait = idle_cycles(take_calm);
        end
        if (take_wait > 0) begin
            take_wait--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        in_fire <= i_rst_n && s_axis_tvalid && s_axis_tready;
        out_fire <= i_rst_n && m_axis_tvalid && m_axis_tready;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                check_reply();
            if (s_axis_tvalid && s_axis_tready) begin
                apply_route_item(s_axis_tuser, s_axis_tdata[163:0], reply);
                expected_replies.push_back(reply);
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t watchdog: no item moved for %0d cycles", $time, stall_cycles);
                $display("Some tests failed");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    initial begin
        int k;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = MODE_ADD;
        m_axis_tready = 1'b0;

        // empty table, spare mode, default route
        push_route(MODE_LOOKUP, 32'h0, 32'h0, 32'h0, 32'h0, 4'h0, 32'h0);
        push_route(MODE_DEL, 32'h0, 32'h0, 32'h0, 32'h0, 4'h0, 32'h0);
        push_route(MODE_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   32'hFFFF_FFFF, 4'hF, 32'hFFFF_FFFF);
        push_route(MODE_ADD, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF, 32'hFFFF_FFFF);
        push_route(MODE_LOOKUP, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 4'h0, 32'h0);
        // duplicates, exact-match delete, ties
        push_route(MODE_ADD, 32'h0A00_0000, 32'hFF00_0000, 32'h0A00_0001, 32'h0A00_00FE,
                   4'h1, 32'd5);
        push_route(MODE_ADD, 32'h0A01_0000, 32'hFFFF_0000, 32'h0A01_0001, 32'h0A01_00FE,
                   4'h2, 32'd5);
        push_route(MODE_ADD, 32'h0A00_0000, 32'hFF00_0000, 32'h0A00_00FF, 32'h0,
                   4'h3, 32'd0);
        push_route(MODE_LOOKUP, 32'h0A01_0203, 32'h0, 32'h0, 32'h0, 4'h0, 32'h0);
        push_route(MODE_DEL, 32'h0A00_0000, 32'hFF00_0000, 32'h0, 32'h0, 4'h0, 32'h0);
        push_route(MODE_DEL, 32'h0A00_0000, 32'hFFFF_0000, 32'h0, 32'h0, 4'h0, 32'h0);
        push_route(MODE_DEL, 32'h0A00_0000, 32'hFF00_0000, 32'h0, 32'h0, 4'h0, 32'h0);
        push_route(MODE_ADD, 32'h0A00_0000, 32'hFF00_0000, 32'h0A00_0002, 32'h0,
                   4'h4, 32'd5);
        push_route(MODE_LOOKUP, 32'h0A01_0203, 32'h0, 32'h0, 32'h0, 4'h0, 32'h0);
        push_route(MODE_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0, 4'h0, 32'h0);
        // host routes up to a full table, then one more
        for (k = 0; k < 12; k++)
            push_route(MODE_ADD, 32'hC0A8_0000 + k, 32'hFFFF_FFFF, $urandom(), $urandom(),
                       4'(k), 32'(k));
        push_route(MODE_ADD, 32'h0, 32'h0, 32'h1, 32'h1, 4'h1, 32'h1);
        // removing the oldest entry shifts the whole table
        push_route(MODE_DEL, 32'h0, 32'h0, 32'h0, 32'h0, 4'h0, 32'h0);
        push_route(MODE_LOOKUP, 32'h0B00_0000, 32'h0, 32'h0, 32'h0, 4'h0, 32'h0);
        push_route(MODE_SPARE, 32'h0, 32'h0, 32'h0, 32'h0, 4'h0, 32'h0);

        gen_random_routes(820);

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_items.size() > 0 || send_busy || expected_replies.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && expected_replies.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* files.f */
+incdir+design
design/rtml_pkg.sv
design/rtml_table.sv
design/rtml_cmp.sv
design/route_table_metric_lookup_unit.sv
verif/tb_route_table_metric_lookup_unit.sv
